FILE: hdl/oxm_tlv_stream_parser_assert.svh
// Assertion macros used by the checker file of the match TLV parser.
`ifndef OXM_TLV_STREAM_PARSER_ASSERT_SVH
`define OXM_TLV_STREAM_PARSER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OTSP_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("parser check failed");

// The consequent must hold in the cycle after the antecedent.
`define OTSP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("parser check failed");

`endif

FILE: hdl/otsp_pkg.sv
package otsp_pkg;

    // Role of a reported byte within its entry.
    typedef enum logic [2:0] {
        ROLE_CLASS_HI = 3'd0,
        ROLE_CLASS_LO = 3'd1,
        ROLE_FIELD    = 3'd2,
        ROLE_LENGTH   = 3'd3,
        ROLE_PAYLOAD  = 3'd4,
        ROLE_DROPPED  = 3'd5
    } byte_role_t;

    // Status reported with every byte.
    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_TABLE_FULL = 2'd1,
        STATUS_TRUNCATED  = 2'd2
    } status_t;

    // Split of the field byte into field code and mask flag.
    localparam logic [7:0] FIELD_CODE_MASK = 8'hfe;
    localparam logic [7:0] HAS_MASK_MASK   = 8'h01;

endpackage

FILE: hdl/oxm_tlv_stream_parser.sv
// Match TLV stream parser. The block takes the serialized match list one byte per
// transfer on the byte channel (data_byte, message_end) and returns exactly one result
// transfer per byte on the result channel: the byte's role (class high, class low,
// field byte, length, payload or dropped), the index of its entry, the entry header
// decoded so far, the payload offset and data for payload bytes, an entry-complete
// flag, a status and an echo of message_end. Each entry is a big-endian 16-bit class,
// a field byte (field code in the upper seven bits, mask flag in bit 0), a length byte
// and that many payload bytes; a zero length finishes the entry on its length byte.
// Once MAX_ENTRIES entries are complete, the next class-high byte and every later byte
// of the message are reported as dropped with table-full status. A message_end on a
// byte that leaves an entry unfinished reports that byte with truncated status. After
// every byte marked message_end the parser starts over for the next message. The
// block sustains one byte per clock cycle while byte_stall is low: the phase and
// header registers are updated from the incoming byte, and the result lands in an
// output register. A new byte is taken while the previous result is still waiting,
// as long as that result is taken in the same cycle; byte_stall is high only while
// a held result is stalled.
module oxm_tlv_stream_parser #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic       clk,
    input  logic       rst_n,

    input  logic       byte_valid,
    output logic       byte_stall,
    input  logic [7:0] data_byte,
    input  logic       message_end,

    output logic        result_valid,
    input  logic        result_stall,
    output logic [2:0]  byte_role,
    output logic [3:0]  entry_index,
    output logic [15:0] tlv_class,
    output logic [6:0]  field_code,
    output logic        has_mask,
    output logic [7:0]  payload_length,
    output logic [7:0]  payload_offset,
    output logic [7:0]  payload_byte,
    output logic        entry_complete,
    output logic [1:0]  status,
    output logic        message_done
);

    // The entry counter must be able to hold MAX_ENTRIES itself.
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    // Parse phase. Dropping doubles as the latched table-full error.
    typedef enum logic [2:0] {
        PH_CLASS_HI = 3'd0,
        PH_CLASS_LO = 3'd1,
        PH_FIELD    = 3'd2,
        PH_LENGTH   = 3'd3,
        PH_PAYLOAD  = 3'd4,
        PH_DROP     = 3'd5
    } phase_t;

    phase_t          phase_reg, phase_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [15:0]     class_reg, class_next;
    logic [6:0]      field_reg, field_next;
    logic            mask_reg, mask_next;
    logic [7:0]      length_reg, length_next;
    logic [7:0]      offset_reg, offset_next;

    logic            valid_reg;
    logic [2:0]      role_reg, role_next;
    logic [3:0]      index_reg;
    logic [15:0]     tclass_reg, tclass_next;
    logic [6:0]      fcode_reg, fcode_next;
    logic            hmask_reg, hmask_next;
    logic [7:0]      plen_reg, plen_next;
    logic [7:0]      poff_reg, poff_next;
    logic [7:0]      pbyte_reg, pbyte_next;
    logic            done_reg, done_next;
    logic [1:0]      status_reg, status_next;
    logic            mdone_reg;

    logic            accept;
    logic [7:0]      offset_inc;
    logic [CW+3:0]   count_wide;

    // A byte is taken unless a finished result is waiting on a stalled receiver.
    assign byte_stall = valid_reg && result_stall;
    assign accept     = byte_valid && !byte_stall;

    assign offset_inc = offset_reg + 8'd1;
    assign count_wide = {4'd0, count_reg};

    // Phase update and result decode for the incoming byte.
    always_comb
    begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        class_next  = class_reg;
        field_next  = field_reg;
        mask_next   = mask_reg;
        length_next = length_reg;
        offset_next = offset_reg;
        role_next   = otsp_pkg::ROLE_DROPPED;
        poff_next   = 8'd0;
        pbyte_next  = 8'd0;
        done_next   = 1'b0;

        unique case (phase_reg)
            PH_CLASS_HI:
            begin
                if (count_reg >= CW'(MAX_ENTRIES))
                begin
                    phase_next = PH_DROP;
                end
                else
                begin
                    class_next  = {data_byte, 8'd0};
                    field_next  = 7'd0;
                    mask_next   = 1'b0;
                    length_next = 8'd0;
                    offset_next = 8'd0;
                    role_next   = otsp_pkg::ROLE_CLASS_HI;
                    phase_next  = PH_CLASS_LO;
                end
            end
            PH_CLASS_LO:
            begin
                class_next = {class_reg[15:8], data_byte};
                role_next  = otsp_pkg::ROLE_CLASS_LO;
                phase_next = PH_FIELD;
            end
            PH_FIELD:
            begin
                field_next = 7'((data_byte & otsp_pkg::FIELD_CODE_MASK) >> 1);
                mask_next  = |(data_byte & otsp_pkg::HAS_MASK_MASK);
                role_next  = otsp_pkg::ROLE_FIELD;
                phase_next = PH_LENGTH;
            end
            PH_LENGTH:
            begin
                length_next = data_byte;
                offset_next = 8'd0;
                role_next   = otsp_pkg::ROLE_LENGTH;
                if (data_byte == 8'd0)
                begin
                    done_next  = 1'b1;
                    count_next = count_reg + CW'(1);
                    phase_next = PH_CLASS_HI;
                end
                else
                begin
                    phase_next = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                role_next   = otsp_pkg::ROLE_PAYLOAD;
                poff_next   = offset_reg;
                pbyte_next  = data_byte;
                offset_next = offset_inc;
                if (offset_inc >= length_reg)
                begin
                    done_next  = 1'b1;
                    count_next = count_reg + CW'(1);
                    phase_next = PH_CLASS_HI;
                end
            end
            default:
            begin
                phase_next = PH_DROP;
            end
        endcase

        // Header fields show the entry as decoded through this byte; the
        // class reads zero on the class-high byte and all read zero when dropped.
        if (phase_next == PH_DROP)
        begin
            tclass_next = 16'd0;
            fcode_next  = 7'd0;
            hmask_next  = 1'b0;
            plen_next   = 8'd0;
        end
        else
        begin
            tclass_next = (role_next == otsp_pkg::ROLE_CLASS_HI) ? 16'd0 : class_next;
            fcode_next  = field_next;
            hmask_next  = mask_next;
            plen_next   = length_next;
        end

        if (phase_next == PH_DROP)
            status_next = otsp_pkg::STATUS_TABLE_FULL;
        else if (message_end && phase_next != PH_CLASS_HI)
            status_next = otsp_pkg::STATUS_TRUNCATED;
        else
            status_next = otsp_pkg::STATUS_OK;
    end

    // Parser state: every message end returns it to its starting values.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_CLASS_HI;
            count_reg  <= '0;
            class_reg  <= 16'd0;
            field_reg  <= 7'd0;
            mask_reg   <= 1'b0;
            length_reg <= 8'd0;
            offset_reg <= 8'd0;
        end
        else if (accept)
        begin
            if (message_end)
            begin
                phase_reg  <= PH_CLASS_HI;
                count_reg  <= '0;
                class_reg  <= 16'd0;
                field_reg  <= 7'd0;
                mask_reg   <= 1'b0;
                length_reg <= 8'd0;
                offset_reg <= 8'd0;
            end
            else
            begin
                phase_reg  <= phase_next;
                count_reg  <= count_next;
                class_reg  <= class_next;
                field_reg  <= field_next;
                mask_reg   <= mask_next;
                length_reg <= length_next;
                offset_reg <= offset_next;
            end
        end
    end

    // Result valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (accept)
            valid_reg <= 1'b1;
        else if (!result_stall)
            valid_reg <= 1'b0;
    end

    // Result payload, loaded on every accepted byte.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            role_reg   <= role_next;
            index_reg  <= count_wide[3:0];
            tclass_reg <= tclass_next;
            fcode_reg  <= fcode_next;
            hmask_reg  <= hmask_next;
            plen_reg   <= plen_next;
            poff_reg   <= poff_next;
            pbyte_reg  <= pbyte_next;
            done_reg   <= done_next;
            status_reg <= status_next;
            mdone_reg  <= message_end;
        end
    end

    assign result_valid   = valid_reg;
    assign byte_role      = role_reg;
    assign entry_index    = index_reg;
    assign tlv_class      = tclass_reg;
    assign field_code     = fcode_reg;
    assign has_mask       = hmask_reg;
    assign payload_length = plen_reg;
    assign payload_offset = poff_reg;
    assign payload_byte   = pbyte_reg;
    assign entry_complete = done_reg;
    assign status         = status_reg;
    assign message_done   = mdone_reg;

endmodule

FILE: hdl/otsp_checker.sv
`include "oxm_tlv_stream_parser_assert.svh"

module otsp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        result_valid,
    input logic        result_stall,
    input logic [2:0]  byte_role,
    input logic [7:0]  payload_offset,
    input logic [7:0]  payload_byte,
    input logic        entry_complete,
    input logic [1:0]  status,
    input logic        message_done
);

    // A stalled result holds its role and data.
    `OTSP_ASSERT_NEXT(a_result_hold, result_valid && result_stall,
        result_valid && $stable(byte_role) && $stable(payload_byte))

    // Offset and data are reported only on payload bytes.
    `OTSP_ASSERT_SAME(a_payload_only, result_valid && byte_role != otsp_pkg::ROLE_PAYLOAD,
        payload_offset == 8'd0 && payload_byte == 8'd0)

    // A dropped byte always carries the table-full status.
    `OTSP_ASSERT_SAME(a_drop_full, result_valid && byte_role == otsp_pkg::ROLE_DROPPED,
        status == otsp_pkg::STATUS_TABLE_FULL)

    // Truncation is reported only on the last byte of a message.
    `OTSP_ASSERT_SAME(a_trunc_end, result_valid && status == otsp_pkg::STATUS_TRUNCATED,
        message_done && !entry_complete)

    // Only a length or payload byte can finish an entry.
    `OTSP_ASSERT_SAME(a_complete_role, result_valid && entry_complete,
        byte_role == otsp_pkg::ROLE_LENGTH || byte_role == otsp_pkg::ROLE_PAYLOAD)

endmodule

bind oxm_tlv_stream_parser otsp_checker u_otsp_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .byte_role      (byte_role),
    .payload_offset (payload_offset),
    .payload_byte   (payload_byte),
    .entry_complete (entry_complete),
    .status         (status),
    .message_done   (message_done)
);
